// ===== rtl/core/mhpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
// No dependencies; imported by the top level and the port checker.
`timescale 1ns / 1ps

package mhpq_pkg;

	// Fixed widths of the priority field and of the key ports.
	localparam int PRIO_W     = 32;
	localparam int KEY_PORT_W = 32;

	// Operation kinds on the kind input.
	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef logic signed [PRIO_W-1:0] prio_t;

endpackage

// ===== rtl/core/mhpq_mem.sv =====
// Heap entry storage: one write port and two read ports with registered read data.
// No package dependency; sized by its parameters.
`timescale 1ns / 1ps

module mhpq_mem #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data is registered and comes out in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue: command port, sift sequencer, result registers.
// Depends on mhpq_pkg and mhpq_mem.
`timescale 1ns / 1ps

// A binary min-heap of (key, priority) entries held in a synchronous memory with one
// write port and two read ports. An item is taken when start is high and busy is low;
// kind selects insert or extract-minimum. Exactly one result follows each item, shown
// for one cycle with done high; the receiver cannot stall it, so it must sample done
// whenever it is asserted. Busy stays high from the accepting edge until the result
// cycle ends. At each heap level the entries read for that level are compared, one
// entry is written back and the next level's reads are issued. An insert into a full
// heap or an extract from an empty one goes straight from idle to the result state.
// Inserting into a full heap drops the entry and reports status full; extracting from
// an empty heap reports status empty with zero key and priority. Priorities are signed
// Q16.16; ties never move an entry past an equal one, and the left child wins a tie on
// the way down. Only the low KEY_BITS bits of a key are kept. The memory needs no
// clearing after reset, since data read from slots at or above the entry count is
// never used.
module min_heap_priority_queue #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic                                     kind,
	input  logic [mhpq_pkg::KEY_PORT_W-1:0]          key_tag,
	input  logic signed [mhpq_pkg::PRIO_W-1:0]       priority_req,
	output logic                                     done,
	output mhpq_pkg::status_t                        status,
	output logic [mhpq_pkg::KEY_PORT_W-1:0]          out_key_tag,
	output logic signed [mhpq_pkg::PRIO_W-1:0]       out_priority,
	output logic [CNT_W-1:0]                         count
);

	import mhpq_pkg::*;

	localparam int AW     = $clog2(CAPACITY);
	localparam int DATA_W = KEY_BITS + PRIO_W;
	localparam int EXT_W  = AW + 2;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
	localparam logic [2:0] S_UP   = 3'd1;  // insert: compare with parent, move up
	localparam logic [2:0] S_EXT  = 3'd2;  // extract: root and last entry arrive
	localparam logic [2:0] S_DOWN = 3'd3;  // extract: compare with children, move down
	localparam logic [2:0] S_WR   = 3'd4;  // write the moving entry into its final slot
	localparam logic [2:0] S_DONE = 3'd5;  // result shown for one cycle

	logic [2:0]          state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [AW-1:0]       idx_q;
	logic [KEY_BITS-1:0] item_key_q;
	prio_t               item_prio_q;
	status_t             status_q;
	logic [KEY_BITS-1:0] out_key_q;
	prio_t               out_prio_q;

	// Memory port signals.
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;

	mhpq_mem #(
		.DEPTH (CAPACITY),
		.DATA_W(DATA_W)
	) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Entries are packed with the key on top and the priority in the low bits.
	logic [KEY_BITS-1:0] key_a, key_b;
	prio_t               prio_a, prio_b;
	logic [DATA_W-1:0]   item_word;

	assign key_a     = rdata_a[DATA_W-1:PRIO_W];
	assign key_b     = rdata_b[DATA_W-1:PRIO_W];
	assign prio_a    = rdata_a[PRIO_W-1:0];
	assign prio_b    = rdata_b[PRIO_W-1:0];
	assign item_word = {item_key_q, item_prio_q};

	logic accept;
	logic heap_full, heap_empty;

	assign accept     = start && (state_q == S_IDLE);
	assign heap_full  = (count_q == CNT_W'(CAPACITY));
	assign heap_empty = (count_q == '0);

	// Moving up: parent of the current slot and of that parent.
	logic [AW-1:0] parent;
	logic [AW-1:0] grand;
	logic          up_swap;

	assign parent  = (idx_q - 1'b1) >> 1;
	assign grand   = (parent - 1'b1) >> 1;
	assign up_swap = (item_prio_q < prio_a);

	// Moving down: children of the current slot live on read ports a (left) and b (right).
	logic [EXT_W-1:0] cnt_e;
	logic [EXT_W-1:0] lc_e, rc_e;
	logic             l_take, r_take;
	prio_t            best_prio;
	logic [AW-1:0]    best;
	logic [EXT_W-1:0] nlc_e;

	always_comb begin
		cnt_e     = EXT_W'(count_q);
		lc_e      = EXT_W'({idx_q, 1'b1});
		rc_e      = lc_e + 1'b1;
		l_take    = (lc_e < cnt_e) && (prio_a < item_prio_q);
		best_prio = l_take ? prio_a : item_prio_q;
		r_take    = (rc_e < cnt_e) && (prio_b < best_prio);
		if (r_take) begin
			best = rc_e[AW-1:0];
		end else begin
			best = lc_e[AW-1:0];
		end
		nlc_e = EXT_W'({best, 1'b1});
	end

	// Next state, memory addresses and write control.
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = item_word;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == KIND_INSERT) begin
						if (heap_full) begin
							state_d = S_DONE;
						end else if (heap_empty) begin
							state_d = S_WR;
						end else begin
							raddr_a = AW'((count_q - 1'b1) >> 1);
							state_d = S_UP;
						end
					end else begin
						if (heap_empty) begin
							state_d = S_DONE;
						end else begin
							raddr_a = '0;
							raddr_b = AW'(count_q - 1'b1);
							state_d = S_EXT;
						end
					end
				end
			end
			S_UP: begin
				we = 1'b1;
				if (up_swap) begin
					// The parent drops into the current slot; the new entry keeps climbing.
					wdata = rdata_a;
					if (parent == '0) begin
						state_d = S_WR;
					end else begin
						raddr_a = grand;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_EXT: begin
				if (heap_empty) begin
					state_d = S_DONE;
				end else begin
					raddr_a = AW'(1);
					raddr_b = AW'(2);
					state_d = S_DOWN;
				end
			end
			S_DOWN: begin
				we = 1'b1;
				if (r_take || l_take) begin
					// The smaller child rises into the current slot.
					wdata = r_take ? rdata_b : rdata_a;
					if (nlc_e >= cnt_e) begin
						state_d = S_WR;
					end else begin
						raddr_a = nlc_e[AW-1:0];
						raddr_b = AW'(nlc_e + 1'b1);
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_WR: begin
				we      = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (kind == KIND_INSERT && !heap_full) begin
					count_q <= count_q + 1'b1;
				end else if (kind == KIND_EXTRACT && !heap_empty) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// Moving entry, its slot and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_key_q  <= key_tag[KEY_BITS-1:0];
					item_prio_q <= priority_req;
					idx_q       <= AW'(count_q);
					out_key_q   <= '0;
					out_prio_q  <= '0;
					if (kind == KIND_INSERT) begin
						status_q <= heap_full ? ST_FULL : ST_OK;
					end else begin
						status_q <= heap_empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_UP: begin
				if (up_swap) begin
					idx_q <= parent;
				end
			end
			S_EXT: begin
				// Root is the answer; the last entry restarts at the root.
				out_key_q   <= key_a;
				out_prio_q  <= prio_a;
				item_key_q  <= key_b;
				item_prio_q <= prio_b;
				idx_q       <= '0;
			end
			S_DOWN: begin
				if (r_take || l_take) begin
					idx_q <= best;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_DONE);
	assign status       = status_q;
	assign out_key_tag  = KEY_PORT_W'(out_key_q);
	assign out_priority = out_prio_q;
	assign count        = count_q;

endmodule

// ===== rtl/core/mhpq_checker.sv =====
// Port-level checks on the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_checker #(
	parameter int CAPACITY = 1024,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input mhpq_pkg::status_t                    status,
	input logic [mhpq_pkg::KEY_PORT_W-1:0]      out_key_tag,
	input logic signed [mhpq_pkg::PRIO_W-1:0]   out_priority,
	input logic [CNT_W-1:0]                     count
);

	import mhpq_pkg::*;

	// An accepted item keeps the block busy until its result has been shown.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// The result cycle ends the operation.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after its result");

	// A failed operation carries no entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> out_key_tag == '0 && out_priority == '0)
		else $error("empty or full result carries an entry");

	// Empty and full reports agree with the entry count.
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != ST_EMPTY || count == '0) &&
		         (status != ST_FULL || count == CNT_W'(CAPACITY)))
		else $error("status disagrees with entry count");

endmodule

bind min_heap_priority_queue mhpq_checker #(
	.CAPACITY(CAPACITY)
) u_mhpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_key_tag (out_key_tag),
	.out_priority(out_priority),
	.count       (count)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the min-heap priority queue: drives insert and extract items,
// predicts every result with its own heap model, and checks each result field by field.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;
	import mhpq_pkg::*;

	localparam int CAPACITY      = 1024;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	// The slowest correct run is about 1450 items plus idle gaps, so this limit leaves
	// a wide margin.
	localparam int CYCLE_LIMIT   = 300000;
	// Settling time after the last result, long enough to catch any stray late strobe.
	localparam int SETTLE_CYCLES = 24;

	// One item as it sits in the pending queue, and one predicted result.
	typedef struct {
		logic                  op;
		logic [KEY_PORT_W-1:0] key;
		prio_t                 prio;
	} heap_cmd_t;

	typedef struct {
		status_t               status;
		logic [KEY_PORT_W-1:0] key;
		prio_t                 prio;
		logic [CNT_W-1:0]      size;
	} heap_result_t;

	// Every input has a known value from time zero.
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  kind         = KIND_INSERT;
	logic [KEY_PORT_W-1:0] key_tag      = '0;
	prio_t                 priority_req = '0;

	logic                  busy;
	logic                  done;
	status_t               status;
	logic [KEY_PORT_W-1:0] out_key_tag;
	prio_t                 out_priority;
	logic [CNT_W-1:0]      count;

	min_heap_priority_queue #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key_tag(key_tag),
		.priority_req(priority_req),
		.done(done),
		.status(status),
		.out_key_tag(out_key_tag),
		.out_priority(out_priority),
		.count(count)
	);

	// Items waiting to be driven, and results owed by the block in order of acceptance.
	heap_cmd_t    pending_cmds[$];
	heap_result_t expected_results[$];

	// The predictor's own copy of the heap.
	logic [KEY_PORT_W-1:0] heap_key [CAPACITY];
	prio_t                 heap_prio[CAPACITY];
	int unsigned           heap_size = 0;

	// Occupancy as the stimulus generator sees it, used only to shape the phases.
	int unsigned gen_size = 0;

	int unsigned total_cmds     = 0;
	int unsigned cmds_accepted  = 0;
	int unsigned results_seen   = 0;
	int unsigned error_count    = 0;
	int unsigned cycle_count    = 0;
	int unsigned inserts_stored = 0;
	int unsigned inserts_full   = 0;
	int unsigned extracts_done  = 0;
	int unsigned extracts_empty = 0;
	int unsigned peak_size      = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void heap_swap(int unsigned a, int unsigned b);
		logic [KEY_PORT_W-1:0] k;
		prio_t                 p;
		k            = heap_key[a];
		p            = heap_prio[a];
		heap_key[a]  = heap_key[b];
		heap_prio[a] = heap_prio[b];
		heap_key[b]  = k;
		heap_prio[b] = p;
	endfunction

	// Applies one accepted item to the model heap and returns the result it must produce.
	// Sifting uses strict less-than, so an entry never passes one of equal priority, and
	// on the way down the left child is checked first and therefore wins a tie.
	function automatic heap_result_t heap_apply(heap_cmd_t cmd);
		heap_result_t r;
		int unsigned  i;
		int unsigned  up;
		int unsigned  lc;
		int unsigned  rc;
		int unsigned  best;
		r.status = ST_OK;
		r.key    = '0;
		r.prio   = '0;
		if (cmd.op == KIND_INSERT) begin
			if (heap_size >= CAPACITY) begin
				// A full heap drops the entry and leaves everything as it was.
				r.status = ST_FULL;
				inserts_full++;
			end else begin
				i            = heap_size;
				heap_key[i]  = cmd.key;
				heap_prio[i] = cmd.prio;
				heap_size++;
				inserts_stored++;
				while (i > 0) begin
					up = (i - 1) / 2;
					if (heap_prio[i] < heap_prio[up]) begin
						heap_swap(i, up);
						i = up;
					end else begin
						break;
					end
				end
				if (heap_size > peak_size)
					peak_size = heap_size;
			end
		end else if (heap_size == 0) begin
			// Extract from an empty heap reports empty with zero key and priority.
			r.status = ST_EMPTY;
			extracts_empty++;
		end else begin
			r.key  = heap_key[0];
			r.prio = heap_prio[0];
			heap_size--;
			extracts_done++;
			if (heap_size > 0) begin
				// The last entry takes the root and sinks to its place.
				heap_key[0]  = heap_key[heap_size];
				heap_prio[0] = heap_prio[heap_size];
				best         = 0;
				do begin
					i  = best;
					lc = 2 * i + 1;
					rc = 2 * i + 2;
					if (lc < heap_size && heap_prio[lc] < heap_prio[best])
						best = lc;
					if (rc < heap_size && heap_prio[rc] < heap_prio[best])
						best = rc;
					if (best != i)
						heap_swap(i, best);
				end while (best != i);
			end
		end
		r.size = CNT_W'(heap_size);
		return r;
	endfunction

	function automatic void queue_cmd(logic op, logic [KEY_PORT_W-1:0] key, prio_t prio);
		heap_cmd_t c;
		c.op   = op;
		c.key  = key;
		c.prio = prio;
		pending_cmds.push_back(c);
		if (op == KIND_INSERT && gen_size < CAPACITY)
			gen_size++;
		else if (op == KIND_EXTRACT && gen_size > 0)
			gen_size--;
	endfunction

	// Most priorities come from a handful of nearby Q16.16 values so that ties are common.
	// The rest are random words, the signed extremes, zero, or plus or minus one LSB.
	function automatic prio_t random_priority();
		int pick;
		int whole;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			whole = $urandom_range(0, 8);
			return prio_t'((whole - 4) * 65536 + ($urandom_range(0, 1) ? 32768 : 0));
		end else if (pick < 85) begin
			return prio_t'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0:       return prio_t'(32'h8000_0000);
				1:       return prio_t'(32'h7FFF_FFFF);
				2:       return prio_t'(32'h0000_0000);
				3:       return prio_t'(32'hFFFF_FFFF);
				default: return prio_t'(32'h0000_0001);
			endcase
		end
	endfunction

	function automatic logic random_kind(int unsigned extract_pct);
		return ($urandom_range(0, 99) < extract_pct) ? KIND_EXTRACT : KIND_INSERT;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (error_count < 40)
			$display("mismatch: %s on result %0d: got %h, expected %h",
				field, results_seen, got, want);
		error_count++;
	endtask

	// Driver. An item is taken at an edge where start is high and busy is low; the
	// prediction is made at that edge from the values that were on the ports. While the
	// block is busy the current item is held. Otherwise the next item is put up unless
	// the driver decides to idle this cycle, which it does about 8 times in 100, except
	// while the count of accepted items runs from 400 to 699, where it never idles.
	always @(posedge clk or negedge arst_n) begin : driver
		heap_cmd_t next_cmd;
		logic      idle_now;
		if (!arst_n) begin
			start        <= 1'b0;
			kind         <= KIND_INSERT;
			key_tag      <= '0;
			priority_req <= '0;
		end else begin
			if (start && !busy) begin
				next_cmd.op   = kind;
				next_cmd.key  = key_tag;
				next_cmd.prio = priority_req;
				expected_results.push_back(heap_apply(next_cmd));
				cmds_accepted++;
			end
			if (!start || !busy) begin
				idle_now = ($urandom_range(0, 99) < 8) &&
					!(cmds_accepted >= 400 && cmds_accepted < 700);
				if (pending_cmds.size() != 0 && !idle_now) begin
					next_cmd     = pending_cmds.pop_front();
					start        <= 1'b1;
					kind         <= next_cmd.op;
					key_tag      <= next_cmd.key;
					priority_req <= next_cmd.prio;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. A result is on the ports for exactly one cycle with done high, and the
	// receiver has no way to hold it, so every strobed cycle is checked against the
	// oldest prediction.
	always @(posedge clk) begin : monitor
		heap_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding", 32'(status), '0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (out_key_tag !== want.key)
					report_mismatch("out_key_tag", out_key_tag, want.key);
				if (out_priority !== want.prio)
					report_mismatch("out_priority", out_priority, want.prio);
				if (count !== want.size)
					report_mismatch("count", 32'(count), 32'(want.size));
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d of %0d items accepted",
				cycle_count, cmds_accepted, total_cmds);
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned n;

		// Directed opening: extract on an empty heap, the key and priority extremes,
		// entries of equal priority, a fractional negative priority, then draining the
		// heap completely and extracting once more from empty.
		queue_cmd(KIND_EXTRACT, 32'hDEAD_BEEF, prio_t'(32'h0001_2345));
		queue_cmd(KIND_INSERT,  32'h0000_0000, prio_t'(32'h0000_0000));
		queue_cmd(KIND_INSERT,  32'hFFFF_FFFF, prio_t'(32'h7FFF_FFFF));
		queue_cmd(KIND_INSERT,  32'hA5A5_A5A5, prio_t'(32'h8000_0000));
		queue_cmd(KIND_INSERT,  32'h5A5A_5A5A, prio_t'(32'hFFFF_FFFF));
		queue_cmd(KIND_INSERT,  32'h0000_0011, prio_t'(32'h0000_0000));
		queue_cmd(KIND_INSERT,  32'h0000_0012, prio_t'(32'h0000_0000));
		queue_cmd(KIND_INSERT,  32'h0000_0013, prio_t'(32'h0001_0000));
		queue_cmd(KIND_INSERT,  32'h0000_0014, prio_t'(32'hFFFF_8000));
		queue_cmd(KIND_INSERT,  32'h0000_0015, prio_t'(32'h0000_0000));
		for (n = 0; n < 10; n++)
			queue_cmd(KIND_EXTRACT, $urandom, prio_t'($urandom));

		// Balanced traffic keeps the heap small, so empty extracts come up often.
		for (n = 0; n < 100; n++)
			queue_cmd(random_kind(50), $urandom, random_priority());

		// Mostly inserts until the heap is full; the occasional extract then sifts down
		// through the deep levels of a large heap.
		while (gen_size < CAPACITY)
			queue_cmd(random_kind(8), $urandom, random_priority());

		// Inserts against a full heap must be dropped; one extract frees a slot for one.
		for (n = 0; n < 3; n++)
			queue_cmd(KIND_INSERT, $urandom, random_priority());
		queue_cmd(KIND_EXTRACT, $urandom, prio_t'($urandom));
		queue_cmd(KIND_INSERT, $urandom, random_priority());
		queue_cmd(KIND_INSERT, $urandom, random_priority());

		// Extract-heavy tail pulling the minimum out of a nearly full heap.
		for (n = 0; n < 100; n++)
			queue_cmd(random_kind(70), $urandom, random_priority());

		total_cmds = pending_cmds.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Every item causes exactly one result, so the run is complete once all items
		// are taken and nothing is owed any more.
		while (cmds_accepted < total_cmds || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d items: %0d inserts stored, %0d refused on a full heap",
			total_cmds, inserts_stored, inserts_full);
		$display("%0d minimum extracts served, %0d on an empty heap, peak occupancy %0d of %0d",
			extracts_done, extracts_empty, peak_size, CAPACITY);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
